>>> rtl/htd_pkg.sv
// Shared types and constants of the hextile tile decoder.
package htd_pkg;

   localparam int TILE_SIZE = 16;

   typedef enum logic [1:0] {
      KIND_FILL     = 2'd0,
      KIND_TILE_END = 2'd1,
      KIND_BAD_XY   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      CSR_RECT_WIDTH  = 2'd0,
      CSR_RECT_HEIGHT = 2'd1,
      CSR_PIXEL_SIZE  = 2'd2
   } csr_index_type;

   typedef enum logic [8:0] {
      PH_TYPE   = 9'b000000001,
      PH_RAW    = 9'b000000010,
      PH_BG     = 9'b000000100,
      PH_FG     = 9'b000001000,
      PH_COUNT  = 9'b000010000,
      PH_SUBCOL = 9'b000100000,
      PH_XY     = 9'b001000000,
      PH_WH     = 9'b010000000,
      PH_DONE   = 9'b100000000
   } phase_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [11:0] pos_x;
      logic [11:0] pos_y;
      logic [4:0]  fill_width;
      logic [4:0]  fill_height;
      logic [31:0] color;
      logic        tile_last;
      logic        rect_last;
   } result_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       rect_start;
   } item_type;

endpackage

>>> rtl/htd_if.sv
// Valid/ready channel interfaces of the hextile tile decoder.
interface htd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       rect_start;
   modport source (output valid, data_byte, rect_start, input ready);
   modport sink (input valid, data_byte, rect_start, output ready);
endinterface

interface htd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [11:0] pos_x;
   logic [11:0] pos_y;
   logic [4:0]  fill_width;
   logic [4:0]  fill_height;
   logic [31:0] color;
   logic        tile_last;
   logic        rect_last;
   modport source (output valid, kind, pos_x, pos_y, fill_width, fill_height, color,
                   tile_last, rect_last, input ready);
   modport sink (input valid, kind, pos_x, pos_y, fill_width, fill_height, color,
                 tile_last, rect_last, output ready);
endinterface

>>> rtl/htd_front.sv
// Input stage: registers accepted items into a two-entry queue.
module htd_front
   import htd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     q_valid,
   input  logic     q_ready,
   output item_type q_item
);
   item_type   mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_ready = (cnt_ff != 2'd2);
   assign q_valid  = (cnt_ff != 2'd0);
   assign q_item   = mem_ff[rp_ff];
   assign push     = in_valid && in_ready;
   assign pop      = q_valid && q_ready;

   always_comb begin
      wp_in  = wp_ff ^ push;
      rp_in  = rp_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wp_ff] <= in_item;
      end
   end
endmodule

>>> rtl/htd_back.sv
// Parser stage: walks tiles and produces fill, tile-end and error results.
module htd_back
   import htd_pkg::*;
#(
   parameter int MAX_RECT_DIM = 4096
) (
   input  logic       clock,
   input  logic       reset,
   input  logic [12:0] rect_width,
   input  logic [12:0] rect_height,
   input  logic [1:0] pixel_size_code,
   input  logic       q_valid,
   output logic       q_ready,
   input  item_type   q_item,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_res
);
   localparam logic [16:0] MAXD = 17'(MAX_RECT_DIM);

   phase_type   phase_ff, phase_in;
   logic [11:0] tl_ff, tl_in, tt_ff, tt_in;
   logic [4:0]  flags_ff, flags_in;
   logic [31:0] bg_ff, bg_in, fg_ff, fg_in, acc_ff, acc_in;
   logic [7:0]  sub_ff, sub_in, posb_ff, posb_in;
   logic [1:0]  pbc_ff, pbc_in;
   logic [3:0]  rc_ff, rc_in, rr_ff, rr_in;
   logic        halt_ff, halt_in;
   logic        ov_ff, ov_in;
   result_type  res_ff, res_in;

   logic        take;
   logic [16:0] cw, ch;
   logic [4:0]  tw, th;
   logic [7:0]  b;
   logic [31:0] acc_n;
   logic [2:0]  pbc_n;
   logic        pix_done;
   logic [4:0]  sx, sy, sw, sh;

   function automatic logic [16:0] clamp(input logic [12:0] v, input logic [16:0] m);
      logic [16:0] r;
      r = (v == 13'd0) ? 17'd1 : {4'd0, v};
      if (r > m) r = m;
      return r;
   endfunction

   function automatic logic [4:0] extent(input logic [16:0] t, input logic [11:0] s);
      logic [16:0] d;
      d = t - {5'd0, s};
      if (t <= {5'd0, s}) return 5'd1;
      if (d > 17'd16) return 5'd16;
      return d[4:0];
   endfunction

   assign q_ready   = !ov_ff || out_ready;
   assign take      = q_valid && q_ready;
   assign out_valid = ov_ff;
   assign out_res   = res_ff;

   always_comb begin
      logic [16:0] nl, nt;
      logic        eot, rlast;
      cw = clamp(rect_width, MAXD);
      ch = clamp(rect_height, MAXD);
      phase_in = phase_ff; tl_in = tl_ff; tt_in = tt_ff; flags_in = flags_ff;
      bg_in = bg_ff; fg_in = fg_ff; acc_in = acc_ff; sub_in = sub_ff;
      posb_in = posb_ff; pbc_in = pbc_ff; rc_in = rc_ff; rr_in = rr_ff;
      halt_in = halt_ff;
      ov_in = ov_ff && !out_ready;
      res_in = res_ff;
      b = q_item.data_byte;
      eot = 1'b0;
      rlast = 1'b0;
      nl = '0; nt = '0;
      if (take && q_item.rect_start) begin
         tl_in = '0; tt_in = '0; bg_in = '0; fg_in = '0;
         phase_in = PH_TYPE; halt_in = 1'b0; acc_in = '0; pbc_in = '0;
      end
      tw = extent(cw, tl_in);
      th = extent(ch, tt_in);
      acc_n = acc_in | ({24'd0, b} << {pbc_in, 3'b000});
      pbc_n = {1'b0, pbc_in} + 3'd1;
      case (pixel_size_code)
         2'd0:    pix_done = 1'b1;
         2'd1:    pix_done = (pbc_n >= 3'd2);
         default: pix_done = (pbc_n >= 3'd4);
      endcase
      sx = {1'b0, posb_ff[7:4]};
      sy = {1'b0, posb_ff[3:0]};
      sw = {1'b0, b[7:4]} + 5'd1;
      sh = {1'b0, b[3:0]} + 5'd1;
      if (take && !halt_in && phase_in != PH_DONE) begin
         res_in = '{kind: KIND_FILL, pos_x: tl_in, pos_y: tt_in, fill_width: tw,
                    fill_height: th, color: bg_in, tile_last: 1'b0, rect_last: 1'b0};
         case (phase_in)
            PH_TYPE: begin
               flags_in = b[4:0]; acc_in = '0; pbc_in = '0;
               if (b[0]) begin
                  phase_in = PH_RAW; rc_in = '0; rr_in = '0;
               end else if (b[1]) begin
                  phase_in = PH_BG;
               end else begin
                  ov_in = 1'b1;
                  if (b[2]) phase_in = PH_FG;
                  else if (b[3]) phase_in = PH_COUNT;
                  else eot = 1'b1;
               end
            end
            PH_RAW: begin
               if (pix_done) begin
                  acc_in = '0; pbc_in = '0; ov_in = 1'b1;
                  res_in.pos_x = tl_in + {8'd0, rc_ff};
                  res_in.pos_y = tt_in + {8'd0, rr_ff};
                  res_in.fill_width = 5'd1; res_in.fill_height = 5'd1;
                  res_in.color = acc_n;
                  if ({1'b0, rc_ff} + 5'd1 < tw) begin
                     rc_in = rc_ff + 4'd1;
                  end else if ({1'b0, rr_ff} + 5'd1 < th) begin
                     rc_in = '0; rr_in = rr_ff + 4'd1;
                  end else begin
                     rc_in = '0; rr_in = '0; eot = 1'b1;
                  end
               end else begin
                  acc_in = acc_n; pbc_in = pbc_n[1:0];
               end
            end
            PH_BG: begin
               if (pix_done) begin
                  bg_in = acc_n; res_in.color = acc_n; ov_in = 1'b1;
                  acc_in = '0; pbc_in = '0;
                  if (flags_ff[2]) phase_in = PH_FG;
                  else if (flags_ff[3]) phase_in = PH_COUNT;
                  else eot = 1'b1;
               end else begin
                  acc_in = acc_n; pbc_in = pbc_n[1:0];
               end
            end
            PH_FG: begin
               if (pix_done) begin
                  fg_in = acc_n; acc_in = '0; pbc_in = '0;
                  if (flags_ff[3]) begin
                     phase_in = PH_COUNT;
                  end else begin
                     ov_in = 1'b1; eot = 1'b1;
                     res_in.kind = KIND_TILE_END; res_in.fill_width = '0;
                     res_in.fill_height = '0; res_in.color = '0;
                  end
               end else begin
                  acc_in = acc_n; pbc_in = pbc_n[1:0];
               end
            end
            PH_COUNT: begin
               sub_in = b;
               if (b == 8'd0) begin
                  ov_in = 1'b1; eot = 1'b1;
                  res_in.kind = KIND_TILE_END; res_in.fill_width = '0;
                  res_in.fill_height = '0; res_in.color = '0;
               end else if (flags_ff[4]) begin
                  phase_in = PH_SUBCOL; acc_in = '0; pbc_in = '0;
               end else begin
                  phase_in = PH_XY;
               end
            end
            PH_SUBCOL: begin
               if (pix_done) begin
                  fg_in = acc_n; acc_in = '0; pbc_in = '0; phase_in = PH_XY;
               end else begin
                  acc_in = acc_n; pbc_in = pbc_n[1:0];
               end
            end
            PH_XY: begin
               posb_in = b; phase_in = PH_WH;
            end
            PH_WH: begin
               ov_in = 1'b1;
               if ({1'b0, sx} + {1'b0, sw} > {1'b0, tw} ||
                   {1'b0, sy} + {1'b0, sh} > {1'b0, th}) begin
                  halt_in = 1'b1;
                  res_in.kind = KIND_BAD_XY; res_in.fill_width = '0;
                  res_in.fill_height = '0; res_in.color = '0;
               end else begin
                  sub_in = sub_ff - 8'd1;
                  res_in.pos_x = tl_in + {7'd0, sx};
                  res_in.pos_y = tt_in + {7'd0, sy};
                  res_in.fill_width = sw; res_in.fill_height = sh;
                  res_in.color = fg_in;
                  if (sub_ff == 8'd1) begin
                     eot = 1'b1;
                  end else if (flags_ff[4]) begin
                     phase_in = PH_SUBCOL; acc_in = '0; pbc_in = '0;
                  end else begin
                     phase_in = PH_XY;
                  end
               end
            end
            default: ;
         endcase
         if (eot) begin
            nl = {5'd0, tl_in} + 17'd16;
            phase_in = PH_TYPE;
            if (nl >= cw) begin
               tl_in = '0;
               nt = {5'd0, tt_in} + 17'd16;
               tt_in = nt[11:0];
               if (nt >= ch) begin
                  phase_in = PH_DONE; rlast = 1'b1;
               end
            end else begin
               tl_in = nl[11:0];
            end
            res_in.tile_last = 1'b1;
            res_in.rect_last = rlast;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TYPE; tl_ff <= '0; tt_ff <= '0; flags_ff <= '0;
         bg_ff <= '0; fg_ff <= '0; acc_ff <= '0; sub_ff <= '0; posb_ff <= '0;
         pbc_ff <= '0; rc_ff <= '0; rr_ff <= '0; halt_ff <= 1'b0; ov_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in; tl_ff <= tl_in; tt_ff <= tt_in; flags_ff <= flags_in;
         bg_ff <= bg_in; fg_ff <= fg_in; acc_ff <= acc_in; sub_ff <= sub_in;
         posb_ff <= posb_in; pbc_ff <= pbc_in; rc_ff <= rc_in; rr_ff <= rr_in;
         halt_ff <= halt_in; ov_ff <= ov_in;
      end
      res_ff <= res_in;
   end
endmodule

>>> rtl/hextile_tile_decoder.sv
// Top level of the hextile tile decoder: register port, input queue and parser.
// The decoder takes one stream byte per clock unless results back up, and gives
// at most one result per byte; an item is held in the two-entry input queue and
// its result registered by the parser, whose single-step state update sets this rate.
// The user must write registers over the APB-style port while idle; not enforced.
module hextile_tile_decoder
   import htd_pkg::*;
#(
   parameter int MAX_RECT_DIM = 4096
) (
   input  logic        clock,
   input  logic        reset,
   htd_req_if.sink     req,
   htd_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   logic [12:0] width_ff, height_ff;
   logic [1:0]  psize_ff;
   logic        q_valid, q_ready, wr;
   item_type    in_item, q_item;
   result_type  res;
   csr_index_type idx;

   assign csr_pready = 1'b1;
   assign idx = csr_index_type'(csr_paddr[3:2]);
   assign wr  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      case (idx)
         CSR_RECT_WIDTH:  csr_prdata = {19'd0, width_ff};
         CSR_RECT_HEIGHT: csr_prdata = {19'd0, height_ff};
         CSR_PIXEL_SIZE:  csr_prdata = {30'd0, psize_ff};
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 13'd16;
         height_ff <= 13'd16;
         psize_ff  <= 2'd2;
      end else if (wr) begin
         case (idx)
            CSR_RECT_WIDTH:  width_ff  <= csr_pwdata[12:0];
            CSR_RECT_HEIGHT: height_ff <= csr_pwdata[12:0];
            CSR_PIXEL_SIZE:  psize_ff  <= csr_pwdata[1:0];
            default: ;
         endcase
      end
   end

   assign in_item = '{data_byte: req.data_byte, rect_start: req.rect_start};

   htd_front u_front (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready), .in_item,
      .q_valid, .q_ready, .q_item
   );

   htd_back #(.MAX_RECT_DIM(MAX_RECT_DIM)) u_back (
      .clock, .reset,
      .rect_width(width_ff), .rect_height(height_ff), .pixel_size_code(psize_ff),
      .q_valid, .q_ready, .q_item,
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_res(res)
   );

   assign rsp.kind        = res.kind;
   assign rsp.pos_x       = res.pos_x;
   assign rsp.pos_y       = res.pos_y;
   assign rsp.fill_width  = res.fill_width;
   assign rsp.fill_height = res.fill_height;
   assign rsp.color       = res.color;
   assign rsp.tile_last   = res.tile_last;
   assign rsp.rect_last   = res.rect_last;
endmodule

>>> rtl/htd_checker.sv
// Port-level checker of the hextile tile decoder and its bind.
module htd_checker
   import htd_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_kind,
   input logic [4:0]  rsp_fill_width,
   input logic        rsp_tile_last,
   input logic        rsp_rect_last,
   input logic        csr_pready
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
   a_rlast: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rect_last |-> rsp_tile_last) else $error("rect end without tile end");
   a_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_BAD_XY |-> !rsp_tile_last && rsp_fill_width == 5'd0)
      else $error("bad error result");
   a_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_FILL |-> rsp_fill_width != 5'd0 && rsp_fill_width <= 5'd16)
      else $error("bad fill width");
   a_pready: assert property (@(posedge clock) csr_pready) else $error("pready low");
endmodule

bind hextile_tile_decoder htd_checker u_checker (
   .clock, .reset,
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_kind(rsp.kind),
   .rsp_fill_width(rsp.fill_width), .rsp_tile_last(rsp.tile_last),
   .rsp_rect_last(rsp.rect_last), .csr_pready
);
